@@ rtl/tarc_pkg.sv @@
// tarc_pkg: shared constants, types and the cordic angle table
// for the tilt angle ramp classifier; depends on nothing
package tarc_pkg;

  localparam int SAMPLE_BITS  = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEP_COUNT   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W       = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam int ATAN_IDX_W   = 5;

  // squares, radicand (sum of squares times 2^16) and root widths
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int RAD_SHIFT  = 16;
  localparam int RAD_W      = SQ_W + RAD_SHIFT;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);
  localparam int REM_W      = ROOT_W + 3;

  // cordic vector and angle accumulator widths
  localparam int CW = ROOT_W + 3;
  localparam int ZW = 25;

  localparam int ANGLE_W   = 16;
  localparam int ANGLE_MAX = 23040;
  localparam int STATE_W   = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_DATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = ANGLE_W;
  localparam int OUT_USER_W = STATE_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [STATE_W-1:0] {
    RAMP_FLAT      = 2'd0,
    RAMP_UP        = 2'd1,
    RAMP_DOWN      = 2'd2,
    RAMP_UNDECIDED = 2'd3
  } ramp_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_ZERO,
    CMD_SOLVE
  } cmd_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UP_LIMIT   = 3'd0,
    REG_DOWN_LIMIT = 3'd1,
    REG_FLAT_LOW   = 3'd2,
    REG_FLAT_HIGH  = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQUARE,
    B_SUM,
    B_ROOT,
    B_ROTATE,
    B_ROUND,
    B_DONE
  } back_state_t;

  typedef struct packed {
    cmd_kind_t                      kind;
    logic signed [SAMPLE_BITS-1:0]  x;
    logic signed [SAMPLE_BITS-1:0]  y;
    logic signed [SAMPLE_BITS-1:0]  z;
  } tarc_cmd_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] up_limit;
    logic signed [ANGLE_W-1:0] down_limit;
    logic signed [ANGLE_W-1:0] flat_low;
    logic signed [ANGLE_W-1:0] flat_high;
  } limits_t;

  // atan(2^-i) in degrees, scaled by 2^16
  function automatic logic signed [ZW-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    case (idx)
      5'd0:    atan_entry = ZW'(2949120);
      5'd1:    atan_entry = ZW'(1740967);
      5'd2:    atan_entry = ZW'(919879);
      5'd3:    atan_entry = ZW'(466945);
      5'd4:    atan_entry = ZW'(234379);
      5'd5:    atan_entry = ZW'(117304);
      5'd6:    atan_entry = ZW'(58666);
      5'd7:    atan_entry = ZW'(29335);
      5'd8:    atan_entry = ZW'(14668);
      5'd9:    atan_entry = ZW'(7334);
      5'd10:   atan_entry = ZW'(3667);
      5'd11:   atan_entry = ZW'(1833);
      5'd12:   atan_entry = ZW'(917);
      5'd13:   atan_entry = ZW'(458);
      5'd14:   atan_entry = ZW'(229);
      5'd15:   atan_entry = ZW'(115);
      5'd16:   atan_entry = ZW'(57);
      5'd17:   atan_entry = ZW'(29);
      5'd18:   atan_entry = ZW'(14);
      5'd19:   atan_entry = ZW'(7);
      5'd20:   atan_entry = ZW'(4);
      5'd21:   atan_entry = ZW'(2);
      5'd22:   atan_entry = ZW'(1);
      default: atan_entry = '0;
    endcase
  endfunction

endpackage

@@ rtl/tarc_front.sv @@
// tarc_front: input beat register and sample decode (hold, zero, solve)
// depends on tarc_pkg
module tarc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tarc_pkg::IN_DATA_W-1:0] s_tdata,  // accel_x, accel_y, accel_z, zero pad
  input  logic [tarc_pkg::IN_USER_W-1:0] s_tuser,  // sample_valid
  input  logic                           q_full,
  output logic                           q_push,
  output tarc_pkg::tarc_cmd_t            q_cmd
);

  localparam int S = tarc_pkg::SAMPLE_BITS;

  logic                held_valid;
  tarc_pkg::tarc_cmd_t held_cmd;
  tarc_pkg::tarc_cmd_t decoded;

  always_comb begin
    decoded.x = s_tdata[S-1:0];
    decoded.y = s_tdata[2*S-1:S];
    decoded.z = s_tdata[3*S-1:2*S];
    if (!s_tuser[0]) begin
      decoded.kind = tarc_pkg::CMD_HOLD;
    end else if (s_tdata[3*S-1:0] == '0) begin
      decoded.kind = tarc_pkg::CMD_ZERO;
    end else begin
      decoded.kind = tarc_pkg::CMD_SOLVE;
    end
  end

  assign q_push   = held_valid && !q_full;
  assign s_tready = !held_valid || !q_full;
  assign q_cmd    = held_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held_valid <= 1'b1;
    end else if (q_push) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_cmd <= decoded;
    end
  end

endmodule

@@ rtl/tarc_queue.sv @@
// tarc_queue: short command queue between front and back
// depends on tarc_pkg
module tarc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tarc_pkg::tarc_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output tarc_pkg::tarc_cmd_t pop_cmd
);

  localparam int DEPTH = tarc_pkg::QUEUE_DEPTH;
  localparam int PW    = tarc_pkg::QPTR_W;
  localparam int CNTW  = tarc_pkg::QCNT_W;

  tarc_pkg::tarc_cmd_t slots [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CNTW-1:0]     count;
  logic                push_ok;
  logic                pop_ok;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/tarc_back.sv @@
// tarc_back: sequencer with bit-serial square root, shared cordic rotator,
// rounding, ramp classification and output register; depends on tarc_pkg
module tarc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  tarc_pkg::tarc_cmd_t             q_cmd,
  input  tarc_pkg::limits_t               limits,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tarc_pkg::OUT_DATA_W-1:0] m_tdata,  // tilt_angle
  output logic [tarc_pkg::OUT_USER_W-1:0] m_tuser   // ramp_state
);

  localparam int S      = tarc_pkg::SAMPLE_BITS;
  localparam int SQ_W   = tarc_pkg::SQ_W;
  localparam int RAD_W  = tarc_pkg::RAD_W;
  localparam int ROOT_W = tarc_pkg::ROOT_W;
  localparam int RCW    = tarc_pkg::ROOT_CNT_W;
  localparam int REM_W  = tarc_pkg::REM_W;
  localparam int CW     = tarc_pkg::CW;
  localparam int ZW     = tarc_pkg::ZW;
  localparam int AW     = tarc_pkg::ANGLE_W;
  localparam int STW    = tarc_pkg::STEP_W;
  localparam logic signed [ZW-1:0] SAT_HI = ZW'(tarc_pkg::ANGLE_MAX);
  localparam logic signed [ZW-1:0] SAT_LO = -SAT_HI;
  localparam logic signed [ZW-1:0] HALF   = ZW'(128);

  tarc_pkg::back_state_t state;
  tarc_pkg::back_state_t state_next;

  tarc_pkg::cmd_kind_t   kind;
  logic signed [S-1:0]   x_r;
  logic signed [S-1:0]   y_r;
  logic signed [S-1:0]   z_r;
  logic [SQ_W-1:0]       ysq;
  logic [SQ_W-1:0]       zsq;
  logic [RAD_W-1:0]      rad;
  logic [REM_W-1:0]      rem;
  logic [ROOT_W-1:0]     root;
  logic [RCW-1:0]        root_cnt;
  logic signed [CW-1:0]  cx;
  logic signed [CW-1:0]  cy;
  logic signed [ZW-1:0]  cz;
  logic [STW-1:0]        step;
  logic signed [AW-1:0]  held_angle;
  logic                  out_valid;
  logic [AW-1:0]         out_angle;
  tarc_pkg::ramp_t       out_state;

  logic signed [SQ_W-1:0] y_prod;
  logic signed [SQ_W-1:0] z_prod;
  logic [SQ_W-1:0]        sum_sq;
  logic [REM_W-1:0]       rem_shift;
  logic [REM_W-1:0]       trial;
  logic [REM_W-1:0]       rem_next;
  logic [ROOT_W-1:0]      root_next;
  logic signed [CW-1:0]   dx;
  logic signed [CW-1:0]   dy;
  logic signed [ZW-1:0]   a_step;
  logic signed [ZW-1:0]   rounded;
  logic signed [ZW-1:0]   saturated;
  logic                   root_last;
  logic                   step_last;
  logic                   out_free;

  function automatic tarc_pkg::ramp_t classify(input logic signed [AW-1:0] a,
                                               input tarc_pkg::limits_t lim);
    if (a > lim.up_limit) begin
      classify = tarc_pkg::RAMP_UP;
    end else if (a < lim.down_limit) begin
      classify = tarc_pkg::RAMP_DOWN;
    end else if (a >= lim.flat_low && a <= lim.flat_high) begin
      classify = tarc_pkg::RAMP_FLAT;
    end else begin
      classify = tarc_pkg::RAMP_UNDECIDED;
    end
  endfunction

  // squares and radicand
  assign y_prod = y_r * y_r;
  assign z_prod = z_r * z_r;
  assign sum_sq = ysq + zsq;

  // one root bit per cycle, restoring method
  always_comb begin
    rem_shift = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial     = REM_W'({root, 2'b01});
    if (rem_shift >= trial) begin
      rem_next  = rem_shift - trial;
      root_next = {root[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_shift;
      root_next = {root[ROOT_W-2:0], 1'b0};
    end
  end

  // one vectoring step per cycle
  assign dx     = cy >>> step;
  assign dy     = cx >>> step;
  assign a_step = tarc_pkg::atan_entry(tarc_pkg::ATAN_IDX_W'(step));

  // round half up to 1/256 degree, then saturate
  always_comb begin
    rounded = (cz + HALF) >>> 8;
    if (rounded > SAT_HI) begin
      saturated = SAT_HI;
    end else if (rounded < SAT_LO) begin
      saturated = SAT_LO;
    end else begin
      saturated = rounded;
    end
  end

  assign root_last = (root_cnt == RCW'(ROOT_W - 1));
  assign step_last = (step == STW'(tarc_pkg::STEP_COUNT - 1));
  assign out_free  = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tarc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      tarc_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = (q_cmd.kind == tarc_pkg::CMD_SOLVE) ? tarc_pkg::B_SQUARE
                                                           : tarc_pkg::B_DONE;
        end
      end
      tarc_pkg::B_SQUARE: state_next = tarc_pkg::B_SUM;
      tarc_pkg::B_SUM:    state_next = tarc_pkg::B_ROOT;
      tarc_pkg::B_ROOT: begin
        if (root_last) begin
          state_next = tarc_pkg::B_ROTATE;
        end
      end
      tarc_pkg::B_ROTATE: begin
        if (step_last) begin
          state_next = tarc_pkg::B_ROUND;
        end
      end
      tarc_pkg::B_ROUND:  state_next = tarc_pkg::B_DONE;
      tarc_pkg::B_DONE: begin
        if (out_free) begin
          state_next = tarc_pkg::B_IDLE;
        end
      end
      default: state_next = tarc_pkg::B_IDLE;
    endcase
  end

  // held angle and output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_angle <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == tarc_pkg::B_ROUND) begin
        held_angle <= AW'(saturated);
      end
      if (state == tarc_pkg::B_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tarc_pkg::B_DONE && out_free) begin
      out_angle <= held_angle;
      out_state <= (kind == tarc_pkg::CMD_ZERO) ? tarc_pkg::RAMP_UNDECIDED
                                                : classify(held_angle, limits);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      tarc_pkg::B_IDLE: begin
        kind <= q_cmd.kind;
        x_r  <= q_cmd.x;
        y_r  <= q_cmd.y;
        z_r  <= q_cmd.z;
      end
      tarc_pkg::B_SQUARE: begin
        ysq <= $unsigned(y_prod);
        zsq <= $unsigned(z_prod);
      end
      tarc_pkg::B_SUM: begin
        rad      <= {sum_sq, {tarc_pkg::RAD_SHIFT{1'b0}}};
        rem      <= '0;
        root     <= '0;
        root_cnt <= '0;
      end
      tarc_pkg::B_ROOT: begin
        rad      <= {rad[RAD_W-3:0], 2'b00};
        rem      <= rem_next;
        root     <= root_next;
        root_cnt <= root_cnt + 1'b1;
        if (root_last) begin
          cx   <= $signed(CW'(root_next));
          cy   <= CW'(x_r) <<< 8;
          cz   <= '0;
          step <= '0;
        end
      end
      tarc_pkg::B_ROTATE: begin
        if (!cy[CW-1]) begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + a_step;
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - a_step;
        end
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_angle;
  assign m_tuser  = out_state;

endmodule

@@ rtl/tilt_angle_ramp_classifier.sv @@
// tilt_angle_ramp_classifier: pitch angle of a three-axis sample, held and classified
// against four limit registers; depends on tarc_pkg, tarc_front, tarc_queue, tarc_back
// a solved sample passes the front register, the queue and the back states square, sum,
// root, rotate, round and done into the output register; an invalid or all-zero sample
// goes from idle to done; the back takes one sample at a time, with 16 cordic steps each
// reset: synchronous rst empties front, queue and output, loads limit defaults, clears angle
module tilt_angle_ramp_classifier (
  input  logic                             clk,
  input  logic                             rst,
  // input beats
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tarc_pkg::IN_DATA_W-1:0]   s_tdata,  // accel_x, accel_y, accel_z, zero pad
  input  logic [tarc_pkg::IN_USER_W-1:0]   s_tuser,  // sample_valid
  // result beats
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tarc_pkg::OUT_DATA_W-1:0]  m_tdata,  // tilt_angle
  output logic [tarc_pkg::OUT_USER_W-1:0]  m_tuser,  // ramp_state
  // limit register writes
  input  logic                             cfg_we,
  input  logic [tarc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tarc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tarc_pkg::limits_t   limits;
  tarc_pkg::tarc_cmd_t push_cmd;
  tarc_pkg::tarc_cmd_t pop_cmd;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;

  // limit registers, defaults are +/-8 degrees and a +/-2 degree flat band
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.up_limit   <= 16'sd2048;
      limits.down_limit <= -16'sd2048;
      limits.flat_low   <= -16'sd512;
      limits.flat_high  <= 16'sd512;
    end else if (cfg_we) begin
      case (cfg_index)
        tarc_pkg::REG_UP_LIMIT:   limits.up_limit   <= cfg_data;
        tarc_pkg::REG_DOWN_LIMIT: limits.down_limit <= cfg_data;
        tarc_pkg::REG_FLAT_LOW:   limits.flat_low   <= cfg_data;
        tarc_pkg::REG_FLAT_HIGH:  limits.flat_high  <= cfg_data;
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // front: takes beats and sorts them into hold, zero or solve commands
  tarc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // queue lets the front keep taking beats while the back is busy
  tarc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  // back: root, cordic, rounding, held angle and classification
  tarc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_cmd    (pop_cmd),
    .limits   (limits),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ rtl/tarc_checker.sv @@
// tarc_checker: port-level assertions for the tilt angle ramp classifier,
// bound to the top level; depends on tarc_pkg
module tarc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [tarc_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [tarc_pkg::OUT_USER_W-1:0]  m_tuser
);

  logic [3:0] pending;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  // samples taken whose result beat is not yet out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_beat && !out_beat) begin
      pending <= pending + 1'b1;
    end else if (out_beat && !in_beat) begin
      pending <= pending - 1'b1;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata) <= tarc_pkg::ANGLE_MAX &&
                  $signed(m_tdata) >= -tarc_pkg::ANGLE_MAX))
    else $error("tilt angle out of range");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != '0)
    else $error("result beat with no sample outstanding");

endmodule

bind tilt_angle_ramp_classifier tarc_checker u_tarc_checker (.*);

@@ bench/tarc_checker.sv @@
`timescale 1ns / 1ps
// tb_tarc_checker: watches the sample, result and limit write channels of the tilt
// angle ramp classifier, predicts each result beat and compares it field by field
// depends on tarc_pkg for widths, the ramp class enum and the register indexes
module tb_tarc_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [tarc_pkg::IN_DATA_W-1:0]   s_tdata,  // accel_x, accel_y, accel_z, zero pad
  input  logic [tarc_pkg::IN_USER_W-1:0]   s_tuser,  // sample_valid
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [tarc_pkg::OUT_DATA_W-1:0]  m_tdata,  // tilt_angle
  input  logic [tarc_pkg::OUT_USER_W-1:0]  m_tuser,  // ramp_state
  input  logic                             cfg_we,
  input  logic [tarc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tarc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               pending_results,
  output int                               fail_count
);

  localparam int SB           = tarc_pkg::SAMPLE_BITS;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [tarc_pkg::ANGLE_W-1:0] angle_t;

  typedef struct {
    angle_t           angle;
    tarc_pkg::ramp_t  ramp;
  } tilt_result_t;

  // atan(2^-i) in degrees, 16 fraction bits
  longint atan_q16 [0:tarc_pkg::TABLE_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  angle_t up_limit, down_limit, flat_low, flat_high;
  angle_t held_angle;
  tilt_result_t expected_q [$];

  initial begin
    pending_results = 0;
    fail_count      = 0;
  end

  // pitch = atan(x / sqrt(y^2 + z^2)) by vectoring cordic, rounded to 1/256 degree
  function automatic angle_t solve_pitch(logic signed [SB-1:0] ax, logic signed [SB-1:0] ay,
                                         logic signed [SB-1:0] az);
    longint xs, ys, zs, rad, root, bitv, cx, cy, acc, dx, dy, res;
    xs = ax;
    ys = ay;
    zs = az;
    rad  = (ys * ys + zs * zs) << 16;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > rad) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rad >= root + bitv) begin
        rad  = rad - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    cx  = root;
    cy  = xs * 256;
    acc = 0;
    for (int i = 0; i < tarc_pkg::STEP_COUNT; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        acc = acc + atan_q16[i];
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        acc = acc - atan_q16[i];
      end
    end
    res = (acc + 128) >>> 8;
    if (res > tarc_pkg::ANGLE_MAX) res = tarc_pkg::ANGLE_MAX;
    if (res < -tarc_pkg::ANGLE_MAX) res = -tarc_pkg::ANGLE_MAX;
    return angle_t'(res);
  endfunction

  // fixed check order decides when limits contradict each other
  function automatic tarc_pkg::ramp_t classify_angle(angle_t a);
    if (a > up_limit) return tarc_pkg::RAMP_UP;
    if (a < down_limit) return tarc_pkg::RAMP_DOWN;
    if (a >= flat_low && a <= flat_high) return tarc_pkg::RAMP_FLAT;
    return tarc_pkg::RAMP_UNDECIDED;
  endfunction

  always @(posedge clk) begin
    logic signed [SB-1:0] sx, sy, sz;
    tilt_result_t res, want;
    if (rst) begin
      up_limit   <= 16'sd2048;
      down_limit <= -16'sd2048;
      flat_low   <= -16'sd512;
      flat_high  <= 16'sd512;
      held_angle = '0;
      expected_q.delete();
      pending_results <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: result beat with nothing expected: angle %0d state %0d",
                     $realtime, $signed(m_tdata), m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if ($signed(m_tdata) !== want.angle || m_tuser !== want.ramp) begin
            if (fail_count < REPORT_LIMIT)
              $display("%0t: mismatch angle exp %0d got %0d, state exp %0d got %0d",
                       $realtime, want.angle, $signed(m_tdata), want.ramp, m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        sx = s_tdata[SB-1:0];
        sy = s_tdata[2*SB-1:SB];
        sz = s_tdata[3*SB-1:2*SB];
        if (s_tuser[0] && sx == 0 && sy == 0 && sz == 0) begin
          // all-zero valid sample keeps the angle and cannot be classified
          res.ramp = tarc_pkg::RAMP_UNDECIDED;
        end else begin
          if (s_tuser[0]) held_angle = solve_pitch(sx, sy, sz);
          res.ramp = classify_angle(held_angle);
        end
        res.angle = held_angle;
        expected_q.push_back(res);
      end
      if (cfg_we) begin
        case (cfg_index)
          tarc_pkg::REG_UP_LIMIT:   up_limit   <= cfg_data;
          tarc_pkg::REG_DOWN_LIMIT: down_limit <= cfg_data;
          tarc_pkg::REG_FLAT_LOW:   flat_low   <= cfg_data;
          tarc_pkg::REG_FLAT_HIGH:  flat_high  <= cfg_data;
          default: ;
        endcase
      end
      pending_results <= expected_q.size();
    end
  end

endmodule

@@ bench/tb_tilt_angle_ramp_classifier.sv @@
`timescale 1ns / 1ps
// tb_tilt_angle_ramp_classifier: drives samples and limit writes into the tilt
// angle ramp classifier under several idling phases; depends on tarc_pkg, the top and tb_tarc_checker
module tb_tilt_angle_ramp_classifier;

  localparam int SB               = tarc_pkg::SAMPLE_BITS;
  localparam int IN_W             = tarc_pkg::IN_DATA_W;
  localparam int IDX_W            = tarc_pkg::CFG_INDEX_W;
  localparam int CFG_W            = tarc_pkg::CFG_DATA_W;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 166;
  localparam int FIRST_UNUSED_REG = 4;
  localparam int DRAIN_CYCLES     = 60;
  localparam int S_MAX            = 8191;
  localparam int S_MIN            = -8192;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                                 clk       = 1'b0;
  logic                                 rst       = 1'b1;
  logic                                 s_tvalid  = 1'b0;
  logic                                 s_tready;
  logic [IN_W-1:0]                      s_tdata   = '0;  // accel_x, accel_y, accel_z, zero pad
  logic [tarc_pkg::IN_USER_W-1:0]       s_tuser   = '0;  // sample_valid
  logic                                 m_tvalid;
  logic                                 m_tready  = 1'b0;
  logic [tarc_pkg::OUT_DATA_W-1:0]      m_tdata;         // tilt_angle
  logic [tarc_pkg::OUT_USER_W-1:0]      m_tuser;         // ramp_state
  logic                                 cfg_we    = 1'b0;
  logic [IDX_W-1:0]                     cfg_index = '0;
  logic [CFG_W-1:0]                     cfg_data  = '0;

  int pending_results;
  int fail_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  tilt_angle_ramp_classifier u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tb_tarc_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending_results(pending_results),
    .fail_count     (fail_count)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default:   begin send_idle_pct = 34; recv_stall_pct = 34; end
    endcase
  endtask

  // one sample beat; called and returns at a falling edge, valid left high
  task automatic send_sample(int ax, int ay, int az, bit ok);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({SB'(az), SB'(ay), SB'(ax)});
    s_tuser  <= ok;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // hold the sender back until every result beat has come out
  task automatic drain;
    s_tvalid <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
  endtask

  // writes all four limits plus one write to an index past the list, which must be ignored
  task automatic program_limits(int up, int down, int lo, int hi);
    cfg_we    <= 1'b1;
    cfg_index <= tarc_pkg::REG_UP_LIMIT;
    cfg_data  <= CFG_W'(up);
    @(negedge clk);
    cfg_index <= tarc_pkg::REG_DOWN_LIMIT;
    cfg_data  <= CFG_W'(down);
    @(negedge clk);
    cfg_index <= tarc_pkg::REG_FLAT_LOW;
    cfg_data  <= CFG_W'(lo);
    @(negedge clk);
    cfg_index <= tarc_pkg::REG_FLAT_HIGH;
    cfg_data  <= CFG_W'(hi);
    @(negedge clk);
    cfg_index <= IDX_W'(FIRST_UNUSED_REG + $urandom_range(3));
    cfg_data  <= CFG_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // mix of sample shapes: mostly solvable ones, some invalid and all-zero beats
  task automatic send_random_sample;
    int pick, ax, ay, az;
    bit ok;
    pick = $urandom_range(99);
    ok   = 1'b1;
    ax   = rand_span(S_MIN, S_MAX);
    ay   = rand_span(S_MIN, S_MAX);
    az   = rand_span(S_MIN, S_MAX);
    if (pick < 7) begin
      ok = 1'b0;
    end else if (pick < 10) begin
      ax = 0; ay = 0; az = 0;
    end else if (pick < 16) begin
      // no lateral or vertical part, angle near a pole
      ay = 0; az = 0;
    end else if (pick < 34) begin
      ax = rand_span(-64, 63); ay = rand_span(-64, 63); az = rand_span(-64, 63);
    end else if (pick < 60) begin
      // near-level vehicle, angles close to the class limits
      az = ($urandom_range(1) ? 1 : -1) * rand_span(3000, S_MAX);
      ay = rand_span(-600, 600);
      ax = rand_span(-1400, 1400);
    end
    send_sample(ax, ay, az, ok);
  endtask

  initial begin
    int up, down, lo, hi;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset limits
    set_idle(IDLE_NONE);
    send_sample(0, 0, 0, 1'b1);            // all-zero valid, held angle still zero
    send_sample(0, 0, 0, 1'b0);            // invalid, zero angle classified flat
    send_sample(S_MAX, 0, 0, 1'b1);        // straight up
    send_sample(S_MIN, 0, 0, 1'b1);        // straight down
    send_sample(S_MIN, S_MIN, S_MIN, 1'b1);
    send_sample(S_MAX, S_MAX, S_MAX, 1'b1);
    send_sample(0, S_MAX, S_MIN, 1'b1);
    send_sample(0, S_MIN, 0, 1'b1);
    send_sample(S_MAX, S_MIN, S_MAX, 1'b0); // invalid, angle kept
    send_sample(0, 0, 0, 1'b1);            // all-zero valid after a nonzero angle
    send_sample(S_MAX, S_MIN, S_MIN, 1'b1);
    send_sample(S_MIN, S_MAX, S_MAX, 1'b1);
    send_sample(1, 0, 0, 1'b1);
    send_sample(-1, 0, 1, 1'b1);
    send_sample(143, 0, 4096, 1'b1);       // around the flat band edges
    send_sample(-143, 0, 4096, 1'b1);
    send_sample(150, 0, 4096, 1'b1);
    send_sample(575, 0, 4096, 1'b1);       // around the up and down limits
    send_sample(576, 0, 4096, 1'b1);
    send_sample(-575, 0, -4096, 1'b1);
    send_sample(-576, 0, 4096, 1'b1);
    send_sample(300, 0, 4096, 1'b1);       // between band and limit
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin up = 23040;  down = -23040; lo = -23040; hi = 23040;  end
        1: begin up = -23040; down = 23040;  lo = 23040;  hi = -23040; end // contradictory
        2: begin up = 0;      down = 0;      lo = 0;      hi = 0;      end
        3: begin up = 5120;   down = -5120;  lo = 256;    hi = -256;   end // empty band
        6: begin
          up = rand_span(-23040, 23040); down = rand_span(-23040, 23040);
          lo = rand_span(-23040, 23040); hi = rand_span(-23040, 23040);
        end
        default: begin
          up = rand_span(0, 7680);   down = rand_span(-7680, 0);
          lo = rand_span(-2560, 0);  hi = rand_span(0, 2560);
        end
      endcase
      program_limits(up, down, lo, hi);
      set_idle(idle_mode_t'(ph % 4));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain();
        send_random_sample();
      end
      drain();
    end

    // let any stray result beat show up
    set_idle(IDLE_NONE);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_tilt_angle_ramp_classifier: clean");
    end else begin
      $display("tb_tilt_angle_ramp_classifier: errors");
    end
    $finish;
  end

  // run limit that reports errors and ends a run that hangs
  initial begin
    #4_000_000;
    $display("tb_tilt_angle_ramp_classifier: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tarc_pkg.sv
rtl/tarc_front.sv
rtl/tarc_queue.sv
rtl/tarc_back.sv
rtl/tilt_angle_ramp_classifier.sv
rtl/tarc_checker.sv
bench/tarc_checker.sv
bench/tb_tilt_angle_ramp_classifier.sv
